@@ src/cbpm_pkg.sv @@
package cbpm_pkg;

    // Frame count of the table; frame_index is four bits wide, so it stays at sixteen.
    localparam int NUM_FRAMES = 16;

    typedef enum logic [2:0] {
        ACT_READ    = 3'd0,
        ACT_UNPIN   = 3'd1,
        ACT_ALLOC   = 3'd2,
        ACT_DISPOSE = 3'd3,
        ACT_FLUSH   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXCEEDED  = 2'd1,
        ST_NOTPINNED = 2'd2,
        ST_PINNED    = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  file_id;
        logic [23:0] page_no;
        logic        mark_dirty;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame_index;
        logic        fill_needed;
        logic        writeback;
        logic [7:0]  wb_file;
        logic [23:0] wb_page;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SWEEP,
        S_INSTALL,
        S_FLUSH,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan_clear;
        logic scan_step;
        logic hit_update;
        logic unpin_update;
        logic dispose_update;
        logic hand_step;
        logic sweep_clear_ref;
        logic sweep_take;
        logic install;
        logic flush_clear;
        logic cnt_clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic hit_pinned;
        logic hand_ref;
        logic hand_pinned;
        logic hand_dirty;
        logic sweep_done;
        logic scan_match;
        logic scan_pinned;
        logic scan_dirty;
    } stat_t;

endpackage

@@ src/cbpm_datapath.sv @@
module cbpm_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  cbpm_pkg::req_t  req,
    input  cbpm_pkg::cmd_t  cmd,
    output cbpm_pkg::stat_t stat,
    output cbpm_pkg::req_t  req_q,
    output logic [3:0]      hit_idx,
    output logic [3:0]      scan_idx,
    output logic [3:0]      hand,
    output logic [7:0]      sel_file,
    output logic [23:0]     sel_page
);
    localparam int IW = (cbpm_pkg::NUM_FRAMES > 1) ? $clog2(cbpm_pkg::NUM_FRAMES) : 1;
    localparam int CW = $clog2(2 * cbpm_pkg::NUM_FRAMES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(cbpm_pkg::NUM_FRAMES - 1);

    logic [7:0]  file_reg  [cbpm_pkg::NUM_FRAMES];
    logic [23:0] page_reg  [cbpm_pkg::NUM_FRAMES];
    logic [7:0]  pin_reg   [cbpm_pkg::NUM_FRAMES];
    logic [cbpm_pkg::NUM_FRAMES-1:0] dirty_reg, valid_reg, ref_reg;
    logic [IW-1:0] hand_reg, scan_reg, hit_reg;
    logic          hit_found_reg;
    logic [CW-1:0] cnt_reg;
    cbpm_pkg::req_t req_reg;
    logic [IW-1:0] hand_nx;
    logic          match;

    assign hand_nx = (hand_reg == LAST_IDX) ? '0 : hand_reg + 1'b1;
    assign match = valid_reg[scan_reg] && file_reg[scan_reg] == req_reg.file_id
        && page_reg[scan_reg] == req_reg.page_no;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
            dirty_reg <= '0;
            valid_reg <= '0;
            ref_reg <= '0;
            hand_reg <= LAST_IDX;
            scan_reg <= '0;
            hit_reg <= '0;
            hit_found_reg <= 1'b0;
            cnt_reg <= '0;
            for (int i = 0; i < cbpm_pkg::NUM_FRAMES; i++)
            begin
                file_reg[i] <= '0;
                page_reg[i] <= '0;
                pin_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load_req)
                req_reg <= req;
            if (cmd.scan_clear)
            begin
                scan_reg <= '0;
                hit_found_reg <= 1'b0;
                hit_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                if (match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_reg <= scan_reg;
                end
                if (scan_reg != LAST_IDX)
                    scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.hit_update)
            begin
                ref_reg[hit_reg] <= 1'b1;
                if (pin_reg[hit_reg] != 8'hFF)
                    pin_reg[hit_reg] <= pin_reg[hit_reg] + 8'd1;
            end
            if (cmd.unpin_update)
            begin
                pin_reg[hit_reg] <= pin_reg[hit_reg] - 8'd1;
                if (req_reg.mark_dirty)
                    dirty_reg[hit_reg] <= 1'b1;
            end
            if (cmd.dispose_update)
            begin
                file_reg[hit_reg] <= '0;
                page_reg[hit_reg] <= '0;
                pin_reg[hit_reg] <= '0;
                dirty_reg[hit_reg] <= 1'b0;
                valid_reg[hit_reg] <= 1'b0;
                ref_reg[hit_reg] <= 1'b0;
            end
            if (cmd.cnt_clear)
                cnt_reg <= '0;
            if (cmd.hand_step)
            begin
                hand_reg <= hand_nx;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.sweep_clear_ref)
                ref_reg[hand_reg] <= 1'b0;
            if (cmd.install)
            begin
                file_reg[hand_reg] <= req_reg.file_id;
                page_reg[hand_reg] <= req_reg.page_no;
                pin_reg[hand_reg] <= 8'd1;
                ref_reg[hand_reg] <= 1'b1;
                valid_reg[hand_reg] <= 1'b1;
                dirty_reg[hand_reg] <= 1'b0;
            end
            if (cmd.flush_clear)
            begin
                file_reg[scan_reg] <= '0;
                page_reg[scan_reg] <= '0;
                pin_reg[scan_reg] <= '0;
                dirty_reg[scan_reg] <= 1'b0;
                valid_reg[scan_reg] <= 1'b0;
                ref_reg[scan_reg] <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.scan_done   = (scan_reg == LAST_IDX);
        stat.hit         = hit_found_reg;
        stat.hit_pinned  = (pin_reg[hit_reg] != 8'd0);
        stat.hand_ref    = ref_reg[hand_reg];
        stat.hand_pinned = (pin_reg[hand_reg] != 8'd0);
        stat.hand_dirty  = dirty_reg[hand_reg];
        stat.sweep_done  = (cnt_reg == CW'(2 * cbpm_pkg::NUM_FRAMES));
        stat.scan_match  = valid_reg[scan_reg] && file_reg[scan_reg] == req_reg.file_id;
        stat.scan_pinned = (pin_reg[scan_reg] != 8'd0);
        stat.scan_dirty  = dirty_reg[scan_reg];
    end

    assign req_q    = req_reg;
    assign hit_idx  = 4'(hit_reg);
    assign scan_idx = 4'(scan_reg);
    assign hand     = 4'(hand_reg);
    assign sel_file = cmd.sweep_take ? file_reg[hand_reg] : file_reg[scan_reg];
    assign sel_page = cmd.sweep_take ? page_reg[hand_reg] : page_reg[scan_reg];
endmodule

@@ src/cbpm_ctrl.sv @@
module cbpm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  cbpm_pkg::stat_t stat,
    input  cbpm_pkg::req_t  req_q,
    input  logic [3:0]      hit_idx,
    input  logic [3:0]      scan_idx,
    input  logic [3:0]      hand,
    input  logic [7:0]      sel_file,
    input  logic [23:0]     sel_page,
    output cbpm_pkg::cmd_t  cmd,
    output cbpm_pkg::rsp_t  rsp
);
    cbpm_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    cbpm_pkg::rsp_t   rsp_reg, rsp_next;
    logic             ov_reg;
    logic             free;
    logic             emit;
    logic             inflag;
    logic [3:0]       pend_frame_reg;
    logic             pend_fill_reg;

    assign free = !ov_reg || out_ready;
    assign in_ready = (state_reg == cbpm_pkg::S_IDLE);
    assign inflag = in_valid && in_ready;

    // Next state and the result launched this cycle.
    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        rsp_next = '0;
        emit = 1'b0;
        unique case (state_reg)
            cbpm_pkg::S_IDLE:
                if (inflag)
                    state_next = cbpm_pkg::S_LOOKUP;
            cbpm_pkg::S_LOOKUP:
            begin
                if (req_q.action > cbpm_pkg::ACT_FLUSH)
                    state_next = cbpm_pkg::S_IDLE;
                else if (req_q.action == cbpm_pkg::ACT_ALLOC)
                    state_next = cbpm_pkg::S_SWEEP;
                else if (req_q.action == cbpm_pkg::ACT_FLUSH)
                    state_next = cbpm_pkg::S_FLUSH;
                else if (stat.scan_done)
                    state_next = cbpm_pkg::S_DECIDE;
            end
            cbpm_pkg::S_DECIDE:
                if (free)
                begin
                    emit = 1'b1;
                    rsp_next.last = 1'b1;
                    state_next = cbpm_pkg::S_IDLE;
                    case (req_q.action)
                        cbpm_pkg::ACT_READ:
                            if (stat.hit)
                                rsp_next.frame_index = hit_idx;
                            else
                            begin
                                emit = 1'b0;
                                state_next = cbpm_pkg::S_SWEEP;
                            end
                        cbpm_pkg::ACT_UNPIN:
                        begin
                            rsp_next.frame_index = stat.hit ? hit_idx : 4'd0;
                            rsp_next.status = (stat.hit && stat.hit_pinned)
                                ? cbpm_pkg::ST_OK : cbpm_pkg::ST_NOTPINNED;
                        end
                        default:
                            rsp_next.frame_index = stat.hit ? hit_idx : 4'd0;
                    endcase
                end
            cbpm_pkg::S_SWEEP:
                if (stat.sweep_done)
                begin
                    if (free)
                    begin
                        emit = 1'b1;
                        rsp_next.status = cbpm_pkg::ST_EXCEEDED;
                        rsp_next.last = 1'b1;
                        state_next = cbpm_pkg::S_IDLE;
                    end
                end
                else
                    state_next = cbpm_pkg::S_INSTALL;
            cbpm_pkg::S_INSTALL:
                // Hand has just advanced onto the frame under inspection.
                if (stat.hand_ref || stat.hand_pinned)
                    state_next = cbpm_pkg::S_SWEEP;
                else if (free)
                begin
                    emit = 1'b1;
                    if (stat.hand_dirty)
                    begin
                        // A dirty victim sends the writeback now and the install result next.
                        rsp_next.frame_index = hand;
                        rsp_next.writeback = 1'b1;
                        rsp_next.wb_file = sel_file;
                        rsp_next.wb_page = sel_page;
                        ret_next = cbpm_pkg::S_IDLE;
                        state_next = cbpm_pkg::S_EMIT;
                    end
                    else
                    begin
                        rsp_next.frame_index = hand;
                        rsp_next.fill_needed = (req_q.action == cbpm_pkg::ACT_READ);
                        rsp_next.last = 1'b1;
                        state_next = cbpm_pkg::S_IDLE;
                    end
                end
            cbpm_pkg::S_FLUSH:
                if (free)
                begin
                    if (stat.scan_match && stat.scan_pinned)
                    begin
                        emit = 1'b1;
                        rsp_next.status = cbpm_pkg::ST_PINNED;
                        rsp_next.frame_index = scan_idx;
                        rsp_next.last = 1'b1;
                        state_next = cbpm_pkg::S_IDLE;
                    end
                    else
                    begin
                        if (stat.scan_match && stat.scan_dirty)
                        begin
                            emit = 1'b1;
                            rsp_next.frame_index = scan_idx;
                            rsp_next.writeback = 1'b1;
                            rsp_next.wb_file = sel_file;
                            rsp_next.wb_page = sel_page;
                        end
                        if (stat.scan_done)
                        begin
                            ret_next = cbpm_pkg::S_IDLE;
                            state_next = emit ? cbpm_pkg::S_EMIT : cbpm_pkg::S_IDLE;
                            if (!emit)
                            begin
                                emit = 1'b1;
                                rsp_next.last = 1'b1;
                            end
                        end
                    end
                end
            cbpm_pkg::S_EMIT:
                if (free)
                begin
                    emit = 1'b1;
                    rsp_next.frame_index = pend_frame_reg;
                    rsp_next.fill_needed = pend_fill_reg;
                    rsp_next.last = 1'b1;
                    state_next = ret_reg;
                end
            default:
                state_next = cbpm_pkg::S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            cbpm_pkg::S_IDLE:
            begin
                cmd.load_req = inflag;
                cmd.scan_clear = 1'b1;
                cmd.cnt_clear = 1'b1;
            end
            cbpm_pkg::S_LOOKUP:
                cmd.scan_step = (req_q.action <= cbpm_pkg::ACT_DISPOSE);
            cbpm_pkg::S_DECIDE:
                if (free)
                begin
                    cmd.hit_update = (req_q.action == cbpm_pkg::ACT_READ) && stat.hit;
                    cmd.unpin_update = (req_q.action == cbpm_pkg::ACT_UNPIN)
                        && stat.hit && stat.hit_pinned;
                    cmd.dispose_update = (req_q.action == cbpm_pkg::ACT_DISPOSE)
                        && stat.hit;
                end
            cbpm_pkg::S_SWEEP:
                cmd.hand_step = !stat.sweep_done;
            cbpm_pkg::S_INSTALL:
                if (stat.hand_ref)
                    cmd.sweep_clear_ref = 1'b1;
                else if (!stat.hand_pinned && free)
                begin
                    cmd.sweep_take = 1'b1;
                    cmd.install = 1'b1;
                end
            cbpm_pkg::S_FLUSH:
                if (free && !(stat.scan_match && stat.scan_pinned))
                begin
                    cmd.flush_clear = stat.scan_match;
                    cmd.scan_step = 1'b1;
                end
            cbpm_pkg::S_EMIT:
                ;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbpm_pkg::S_IDLE;
            ret_reg <= cbpm_pkg::S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            ret_reg <= ret_next;
            state_reg <= state_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // The closing result after a writeback takes its frame and fill flag from here.
    always_ff @(posedge clk)
    begin
        if (emit)
            rsp_reg <= rsp_next;
        if (state_reg == cbpm_pkg::S_INSTALL)
        begin
            pend_frame_reg <= hand;
            pend_fill_reg <= (req_q.action == cbpm_pkg::ACT_READ);
        end
        else if (state_reg == cbpm_pkg::S_FLUSH)
        begin
            pend_frame_reg <= 4'd0;
            pend_fill_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign rsp = rsp_reg;
endmodule

@@ src/clock_buffer_pool_manager_unit.sv @@
// A read scans all frames, one per cycle, before it decides on a hit.
// A miss adds a clock sweep of up to 2 * NUM_FRAMES frames.
// Flush walks the frames one per cycle while the output is free to take a result.
// One transaction is processed at a time; the input is held off until the last result.
// Reset (rst_n, asynchronous) invalidates every frame and puts the hand at the last frame.
module clock_buffer_pool_manager_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cbpm_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cbpm_pkg::rsp_t out_data
);
    // The controller sequences lookup, sweep and flush; the datapath holds the frame table.
    cbpm_pkg::cmd_t  cmd;
    cbpm_pkg::stat_t stat;
    cbpm_pkg::req_t  req_q;
    logic [3:0]      hit_idx, scan_idx, hand;
    logic [7:0]      sel_file;
    logic [23:0]     sel_page;

    cbpm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .stat(stat),
        .req_q(req_q), .hit_idx(hit_idx), .scan_idx(scan_idx), .hand(hand),
        .sel_file(sel_file), .sel_page(sel_page)
    );

    cbpm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .req_q(req_q),
        .hit_idx(hit_idx), .scan_idx(scan_idx), .hand(hand), .sel_file(sel_file),
        .sel_page(sel_page), .cmd(cmd), .rsp(out_data)
    );
endmodule
